@@ src/mfcd_pkg.sv @@
// Package: shared types, constants and codes of the marker framed command deframer.
`default_nettype none

package mfcd_pkg;

    // Default frame geometry
    localparam int LONG_FRAME_BYTES_DEF  = 20;
    localparam int SHORT_FRAME_BYTES_DEF = 12;
    localparam int MARKER_RUN_DEF        = 5;

    // Bytes of one command kept for the result: id plus four 16-bit values
    localparam int CMD_BYTES = 9;

    // Configuration port
    localparam int CFG_INDEX_W = 3;

    typedef logic [7:0] byte_t;
    typedef byte_t [CMD_BYTES-1:0] cmd_bytes_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER_BYTE   = 3'd0,
        CFG_TRAILER_BYTE  = 3'd1,
        CFG_TELEMETRY_ID  = 3'd2,
        CFG_SET_PWM_ID    = 3'd3,
        CFG_READ_ANGLE_ID = 3'd4
    } cfg_index_t;

    localparam byte_t HEADER_BYTE_RST   = 8'd200;
    localparam byte_t TRAILER_BYTE_RST  = 8'd201;
    localparam byte_t TELEMETRY_ID_RST  = 8'd110;
    localparam byte_t SET_PWM_ID_RST    = 8'd100;
    localparam byte_t READ_ANGLE_ID_RST = 8'd101;

    typedef struct packed {
        byte_t header_byte;
        byte_t trailer_byte;
        byte_t telemetry_id;
        byte_t set_pwm_id;
        byte_t read_angle_id;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_ACK        = 2'd0,
        KIND_TELEMETRY  = 2'd1,
        KIND_SET_PWM    = 2'd2,
        KIND_READ_ANGLE = 2'd3
    } cmd_kind_t;

    // Frame end info handed from the scan stage to the check stage
    typedef struct packed {
        logic  valid;     // a frame end is waiting for its checksum byte
        logic  hdr_ok;    // header run matched
        logic  sum_full;  // checksum byte sits past the header run
        byte_t sum_lhs;   // running sum minus the trailer run
    } frame_end_t;

endpackage

`default_nettype wire

@@ src/mfcd_mem.sv @@
// Frame store: byte memory with one write port and one registered read port.
`default_nettype none

module mfcd_mem
    import mfcd_pkg::*;
#(
    parameter int DEPTH = LONG_FRAME_BYTES_DEF,
    parameter int AW    = $clog2(LONG_FRAME_BYTES_DEF)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire byte_t         wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output byte_t              rdata
);

    byte_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/mfcd_scan.sv @@
// Scan stage: write position, marker runs, running sum and command byte copies.
`default_nettype none

module mfcd_scan
    import mfcd_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF,
    parameter int MARKER_RUN        = MARKER_RUN_DEF,
    parameter int PW                = $clog2(LONG_FRAME_BYTES_DEF)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          in_fire,
    input  wire byte_t         rx_byte,
    input  wire logic          hold,
    output logic [PW-1:0]      wr_addr,
    output logic               rd_en,
    output logic [PW-1:0]      rd_addr,
    output frame_end_t         frame_end,
    output cmd_bytes_t         cmd_bytes
);

    localparam int RW = $clog2(MARKER_RUN + 1);
    localparam logic [PW-1:0] LONG_END  = PW'(LONG_FRAME_BYTES - 1);
    localparam logic [PW-1:0] SHORT_END = PW'(SHORT_FRAME_BYTES - 1);
    localparam logic [RW-1:0] RUN_MAX   = RW'(MARKER_RUN);
    localparam byte_t         RUN_MUL   = 8'(MARKER_RUN);

    logic [PW-1:0] pos_reg, pos_next;
    logic [RW-1:0] run_reg, run_next;
    byte_t         prev_reg;
    byte_t         sum_reg, sum_next;
    byte_t         hdr_first_reg, hdr_first_next;
    logic          hdr_same_reg, hdr_same_next;
    cmd_bytes_t    cmd_reg, cmd_next;
    frame_end_t    end_reg, end_next;

    logic          at_end_index;
    logic          past_header;
    logic          frame_done;
    byte_t         sum_cur;

    // Per-byte tracking of the current pass
    always_comb
    begin
        past_header  = int'(pos_reg) >= MARKER_RUN;
        at_end_index = (pos_reg == LONG_END) ||
                       ((SHORT_FRAME_BYTES <= LONG_FRAME_BYTES) && (pos_reg == SHORT_END));

        // equal-byte run ending here, saturated at the marker length
        if (pos_reg == '0)
        begin
            run_next = RW'(1);
        end
        else if (rx_byte == prev_reg)
        begin
            run_next = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + RW'(1);
        end
        else
        begin
            run_next = RW'(1);
        end

        frame_done = at_end_index && (run_next == RUN_MAX) && (rx_byte == cfg.trailer_byte);

        // sum of bytes from the end of the header run up to here
        sum_cur = past_header ? sum_reg + rx_byte : sum_reg;

        // header run: first byte and whether the run repeats it
        hdr_first_next = hdr_first_reg;
        hdr_same_next  = hdr_same_reg;
        if (pos_reg == '0)
        begin
            hdr_first_next = rx_byte;
            hdr_same_next  = 1'b1;
        end
        else if (!past_header)
        begin
            hdr_same_next = hdr_same_reg && (rx_byte == hdr_first_reg);
        end

        // copies of the id and PWM bytes
        cmd_next = cmd_reg;
        for (int j = 0; j < CMD_BYTES; j++)
        begin
            if (int'(pos_reg) == MARKER_RUN + j)
            begin
                cmd_next[j] = rx_byte;
            end
        end

        if (frame_done || (pos_reg == LONG_END))
        begin
            pos_next = '0;
            sum_next = '0;
        end
        else
        begin
            pos_next = pos_reg + PW'(1);
            sum_next = sum_cur;
        end

        // frame end info for the check stage
        end_next.valid    = frame_done;
        end_next.hdr_ok   = past_header && hdr_same_reg && (hdr_first_reg == cfg.header_byte);
        end_next.sum_full = int'(pos_reg) >= 2 * MARKER_RUN;
        end_next.sum_lhs  = sum_cur - RUN_MUL * rx_byte;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            run_reg       <= '0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            hdr_first_reg <= '0;
            hdr_same_reg  <= 1'b0;
            cmd_reg       <= '0;
            end_reg       <= '0;
        end
        else if (in_fire)
        begin
            pos_reg       <= pos_next;
            run_reg       <= run_next;
            prev_reg      <= rx_byte;
            sum_reg       <= sum_next;
            hdr_first_reg <= hdr_first_next;
            hdr_same_reg  <= hdr_same_next;
            cmd_reg       <= cmd_next;
            end_reg       <= end_next;
        end
        else if (!hold)
        begin
            end_reg.valid <= 1'b0;
        end
    end

    // Store write at the position, checksum byte read from the marker length back
    assign wr_addr   = pos_reg;
    assign rd_en     = in_fire && past_header;
    assign rd_addr   = pos_reg - PW'(MARKER_RUN);
    assign frame_end = end_reg;
    assign cmd_bytes = cmd_reg;

endmodule

`default_nettype wire

@@ src/mfcd_out.sv @@
// Check stage: checksum compare, command decode and result register.
`default_nettype none

module mfcd_out
    import mfcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire frame_end_t frame_end,
    input  wire byte_t      ck_byte,
    input  wire cmd_bytes_t cmd_bytes,
    output logic            hold,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      command_kind,
    output logic [15:0]     pwm_a,
    output logic [15:0]     pwm_b,
    output logic [15:0]     pwm_c,
    output logic [15:0]     pwm_d
);

    logic       out_valid_reg;
    cmd_kind_t  kind_reg, kind_next;
    logic [15:0] pwm_a_reg, pwm_b_reg, pwm_c_reg, pwm_d_reg;
    logic [15:0] pwm_a_next, pwm_b_next, pwm_c_next, pwm_d_next;
    logic       ck_ok;
    logic       result;
    byte_t      id;

    // Checksum and command decode
    always_comb
    begin
        id     = cmd_bytes[0];
        ck_ok  = frame_end.sum_full ? (frame_end.sum_lhs == ck_byte + ck_byte)
                                    : (ck_byte == 8'd0);
        result = frame_end.valid && frame_end.hdr_ok && ck_ok;

        pwm_a_next = '0;
        pwm_b_next = '0;
        pwm_c_next = '0;
        pwm_d_next = '0;
        if (id == cfg.telemetry_id)
        begin
            kind_next = KIND_TELEMETRY;
        end
        else if (id == cfg.set_pwm_id)
        begin
            kind_next  = KIND_SET_PWM;
            pwm_a_next = {cmd_bytes[1], cmd_bytes[2]};
            pwm_b_next = {cmd_bytes[3], cmd_bytes[4]};
            pwm_c_next = {cmd_bytes[5], cmd_bytes[6]};
            pwm_d_next = {cmd_bytes[7], cmd_bytes[8]};
        end
        else if (id == cfg.read_angle_id)
        begin
            kind_next = KIND_READ_ANGLE;
        end
        else
        begin
            kind_next = KIND_ACK;
        end
    end

    assign hold = out_valid_reg && !out_ready;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            out_valid_reg <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && result)
        begin
            kind_reg  <= kind_next;
            pwm_a_reg <= pwm_a_next;
            pwm_b_reg <= pwm_b_next;
            pwm_c_reg <= pwm_c_next;
            pwm_d_reg <= pwm_d_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_kind = kind_reg;
    assign pwm_a        = pwm_a_reg;
    assign pwm_b        = pwm_b_reg;
    assign pwm_c        = pwm_c_reg;
    assign pwm_d        = pwm_d_reg;

endmodule

`default_nettype wire

@@ src/marker_framed_command_deframer.sv @@
// Top level of the marker framed command deframer.
// Takes one received byte per cycle while the input is not stalled. Each byte is written
// into the frame store at the current position; when a byte at the short or long frame
// end index closes a run of trailer bytes, the checksum byte is read back from the store
// into the registered read port along with the registered frame end info, and a decoded
// command is then registered into the result register once that register is free.
// Input stalls only when a frame end is waiting for its check while the result register
// still holds an item that has not been taken. The store needs no clearing pass: the
// checksum byte is always written earlier in the same frame, and the id and PWM bytes are
// kept in reset-cleared copies.
`default_nettype none

module marker_framed_command_deframer
    import mfcd_pkg::*;
#(
    parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
    parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF,
    parameter int MARKER_RUN        = MARKER_RUN_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  command_kind,
    output logic [15:0]                 pwm_a,
    output logic [15:0]                 pwm_b,
    output logic [15:0]                 pwm_c,
    output logic [15:0]                 pwm_d
);

    localparam int PW = $clog2(LONG_FRAME_BYTES);

    cfg_t          cfg_reg;
    logic          in_fire;
    logic          hold;
    logic [PW-1:0] wr_addr;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    byte_t         ck_byte;
    frame_end_t    frame_end;
    cmd_bytes_t    cmd_bytes;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte   <= HEADER_BYTE_RST;
            cfg_reg.trailer_byte  <= TRAILER_BYTE_RST;
            cfg_reg.telemetry_id  <= TELEMETRY_ID_RST;
            cfg_reg.set_pwm_id    <= SET_PWM_ID_RST;
            cfg_reg.read_angle_id <= READ_ANGLE_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_BYTE:   cfg_reg.header_byte   <= cfg_data;
                CFG_TRAILER_BYTE:  cfg_reg.trailer_byte  <= cfg_data;
                CFG_TELEMETRY_ID:  cfg_reg.telemetry_id  <= cfg_data;
                CFG_SET_PWM_ID:    cfg_reg.set_pwm_id    <= cfg_data;
                CFG_READ_ANGLE_ID: cfg_reg.read_angle_id <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input handshake: block only when a pending frame end cannot move on
    assign in_ready = !(frame_end.valid && hold);
    assign in_fire  = in_valid && in_ready;

    mfcd_scan #(
        .LONG_FRAME_BYTES  (LONG_FRAME_BYTES),
        .SHORT_FRAME_BYTES (SHORT_FRAME_BYTES),
        .MARKER_RUN        (MARKER_RUN),
        .PW                (PW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .hold      (hold),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .frame_end (frame_end),
        .cmd_bytes (cmd_bytes)
    );

    mfcd_mem #(
        .DEPTH (LONG_FRAME_BYTES),
        .AW    (PW)
    ) u_mem (
        .clk   (clk),
        .we    (in_fire),
        .waddr (wr_addr),
        .wdata (rx_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ck_byte)
    );

    mfcd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .frame_end    (frame_end),
        .ck_byte      (ck_byte),
        .cmd_bytes    (cmd_bytes),
        .hold         (hold),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command_kind (command_kind),
        .pwm_a        (pwm_a),
        .pwm_b        (pwm_b),
        .pwm_c        (pwm_c),
        .pwm_d        (pwm_d)
    );

endmodule

`default_nettype wire

@@ test/tb_marker_framed_command_deframer.sv @@
// Testbench for the marker framed command deframer: directed frames, then random phases
`timescale 1ns / 100ps

module tb_marker_framed_command_deframer;
    import mfcd_pkg::*;

    localparam int FRAME_LONG     = LONG_FRAME_BYTES_DEF;
    localparam int FRAME_SHORT    = SHORT_FRAME_BYTES_DEF;
    localparam int RUN            = MARKER_RUN_DEF;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int NUM_PHASES     = 7;
    localparam int PRESSURE_PHASE = 3;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_ROWS       = 16;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] pwm_a;
        logic [15:0] pwm_b;
        logic [15:0] pwm_c;
        logic [15:0] pwm_d;
    } command_t;

    typedef enum {SHAPE_SHORT, SHAPE_LONG, SHAPE_NOISE} frame_shape_t;
    typedef enum {DEF_NONE, DEF_HEADER, DEF_CHECKSUM, DEF_TRAILER} frame_defect_t;

    // One stimulus row; typed rows carry their own expected outcome
    typedef struct {
        frame_shape_t  shape;
        frame_defect_t defect;
        byte_t         id;
        logic [63:0]   payload;
        bit            typed;
        bit            exp_hit;
        command_t      exp_cmd;
    } frame_row_t;

    localparam command_t NO_CMD = '0;

    // DUT connections
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             command_kind;
    logic [15:0]            pwm_a;
    logic [15:0]            pwm_b;
    logic [15:0]            pwm_c;
    logic [15:0]            pwm_d;

    // Predictor state: settings, frame store image and write position
    cfg_t        cfg_img = '{HEADER_BYTE_RST, TRAILER_BYTE_RST, TELEMETRY_ID_RST,
                             SET_PWM_ID_RST, READ_ANGLE_ID_RST};
    byte_t       store_img [FRAME_LONG];
    int unsigned wpos = 0;

    command_t    pending_cmds [$];
    command_t    want_cmd;
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned frame_items  = 0;
    int unsigned cycles       = 0;
    bit          idle_on      = 1'b1;
    bit          hold_req     = 1'b0;

    // Directed frames, all at reset settings
    frame_row_t directed_rows [NUM_ROWS] = '{
        '{SHAPE_SHORT, DEF_NONE, TELEMETRY_ID_RST, 64'd0, 1'b1, 1'b1,
          '{KIND_TELEMETRY, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{SHAPE_SHORT, DEF_NONE, READ_ANGLE_ID_RST, 64'd0, 1'b1, 1'b1,
          '{KIND_READ_ANGLE, 16'h0, 16'h0, 16'h0, 16'h0}},
        // short set-pwm after reset picks up its checksum and trailer bytes, then cleared bytes
        '{SHAPE_SHORT, DEF_NONE, SET_PWM_ID_RST, 64'd0, 1'b0, 1'b0, NO_CMD},
        '{SHAPE_SHORT, DEF_NONE, 8'h00, 64'd0, 1'b1, 1'b1,
          '{KIND_ACK, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{SHAPE_SHORT, DEF_NONE, 8'hFF, 64'd0, 1'b1, 1'b1,
          '{KIND_ACK, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{SHAPE_LONG, DEF_NONE, SET_PWM_ID_RST, 64'd0, 1'b1, 1'b1,
          '{KIND_SET_PWM, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{SHAPE_LONG, DEF_NONE, SET_PWM_ID_RST, {64{1'b1}}, 1'b1, 1'b1,
          '{KIND_SET_PWM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
        // short set-pwm reads stale bytes from the long frame before
        '{SHAPE_SHORT, DEF_NONE, SET_PWM_ID_RST, 64'd0, 1'b0, 1'b0, NO_CMD},
        '{SHAPE_LONG, DEF_NONE, SET_PWM_ID_RST, 64'h0123456789ABCDEF, 1'b1, 1'b1,
          '{KIND_SET_PWM, 16'h0123, 16'h4567, 16'h89AB, 16'hCDEF}},
        '{SHAPE_LONG, DEF_NONE, SET_PWM_ID_RST, 64'h8040201008040201, 1'b1, 1'b1,
          '{KIND_SET_PWM, 16'h8040, 16'h2010, 16'h0804, 16'h0201}},
        '{SHAPE_LONG, DEF_NONE, SET_PWM_ID_RST, 64'h7FBFDFEFF7FBFDFE, 1'b1, 1'b1,
          '{KIND_SET_PWM, 16'h7FBF, 16'hDFEF, 16'hF7FB, 16'hFDFE}},
        '{SHAPE_LONG, DEF_HEADER, TELEMETRY_ID_RST, 64'd0, 1'b1, 1'b0, NO_CMD},
        '{SHAPE_LONG, DEF_CHECKSUM, SET_PWM_ID_RST, 64'h1122334455667788,
          1'b1, 1'b0, NO_CMD},
        '{SHAPE_SHORT, DEF_CHECKSUM, READ_ANGLE_ID_RST, 64'd0, 1'b1, 1'b0, NO_CMD},
        // broken trailer: no end at the last index, position wraps
        '{SHAPE_LONG, DEF_TRAILER, SET_PWM_ID_RST, 64'h0F0F0F0F0F0F0F0F,
          1'b0, 1'b0, NO_CMD},
        '{SHAPE_LONG, DEF_NONE, TELEMETRY_ID_RST, 64'hA5A5A5A5A5A5A5A5, 1'b1, 1'b1,
          '{KIND_TELEMETRY, 16'h0, 16'h0, 16'h0, 16'h0}}
    };

    // Settings per random phase; the last one is drawn at run time
    cfg_t phase_cfg [NUM_PHASES] = '{
        '{HEADER_BYTE_RST, TRAILER_BYTE_RST, TELEMETRY_ID_RST,
          SET_PWM_ID_RST, READ_ANGLE_ID_RST},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'h55, 8'hAA, 8'h07, 8'h08, 8'h09},
        '{8'hA5, 8'h5A, 8'h80, 8'h80, 8'h7F},
        '{8'h3C, 8'hC3, 8'h11, 8'h22, 8'h22},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    marker_framed_command_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command_kind (command_kind),
        .pwm_a        (pwm_a),
        .pwm_b        (pwm_b),
        .pwm_c        (pwm_c),
        .pwm_d        (pwm_d)
    );

    always #10 clk = ~clk;

    initial
    begin
        foreach (store_img[i])
            store_img[i] = 8'h00;
    end

    // Store read; anything past the end reads as zero
    function automatic byte_t store_rd(input int unsigned idx);
        return (idx < FRAME_LONG) ? store_img[idx] : 8'h00;
    endfunction

    // Predictor: write one byte, return 1 with the command when a good frame closes
    function automatic bit deframe_byte(input byte_t value, output command_t cmd);
        int unsigned p;
        int unsigned ck_idx;
        byte_t       ck_sum;
        byte_t       id;
        bit          closes;
        cmd = NO_CMD;
        p = wpos;
        if (p >= FRAME_LONG)
            p = 0;
        store_img[p] = value;
        closes = (p == FRAME_LONG - 1) || (p == FRAME_SHORT - 1);
        for (int unsigned k = 0; k < RUN; k++)
        begin
            if (p < k)
                closes = 1'b0;
            else if (store_rd(p - k) != cfg_img.trailer_byte)
                closes = 1'b0;
        end
        if (!closes)
        begin
            p++;
            wpos = (p >= FRAME_LONG) ? 0 : p;
            return 1'b0;
        end
        wpos = 0;
        // header run, then checksum over id and payload
        for (int unsigned i = 0; i < RUN; i++)
            if (store_rd(i) != cfg_img.header_byte)
                return 1'b0;
        if (p < RUN)
            return 1'b0;
        ck_idx = p - RUN;
        ck_sum = 8'h00;
        for (int unsigned i = RUN; i < ck_idx; i++)
            ck_sum = ck_sum + store_rd(i);
        if (ck_sum != store_rd(ck_idx))
            return 1'b0;
        id = store_rd(RUN);
        if (id == cfg_img.telemetry_id)
            cmd.kind = KIND_TELEMETRY;
        else if (id == cfg_img.set_pwm_id)
        begin
            cmd.kind  = KIND_SET_PWM;
            cmd.pwm_a = {store_rd(RUN + 1), store_rd(RUN + 2)};
            cmd.pwm_b = {store_rd(RUN + 3), store_rd(RUN + 4)};
            cmd.pwm_c = {store_rd(RUN + 5), store_rd(RUN + 6)};
            cmd.pwm_d = {store_rd(RUN + 7), store_rd(RUN + 8)};
        end
        else if (id == cfg_img.read_angle_id)
            cmd.kind = KIND_READ_ANGLE;
        else
            cmd.kind = KIND_ACK;
        return 1'b1;
    endfunction

    // Offer one byte, wait for it to be taken, then queue its outcome
    task automatic send_byte(input byte_t value, input bit typed, input bit typed_hit,
                             input command_t typed_cmd);
        int unsigned gap;
        command_t    predicted;
        bit          hit;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (!in_ready);
        hit = deframe_byte(value, predicted);
        if (typed)
        begin
            if (typed_hit)
                pending_cmds.push_back(typed_cmd);
        end
        else if (hit)
            pending_cmds.push_back(predicted);
    endtask

    // Fill up to the next frame start with bytes that cannot close a frame
    task automatic align_to_start();
        byte_t fill;
        while (wpos != 0)
        begin
            do fill = byte_t'($urandom_range(0, 255)); while (fill == cfg_img.trailer_byte);
            send_byte(fill, 1'b0, 1'b0, NO_CMD);
        end
    endtask

    // Build and send one row: a framed command or a burst of noise
    task automatic send_frame(input frame_row_t row, input bit aligned);
        byte_t fb [$];
        byte_t ck_sum;
        byte_t flip;
        int    n;
        if (row.shape == SHAPE_NOISE)
        begin
            n = $urandom_range(1, 30);
            repeat (n)
            begin
                if ($urandom_range(0, 9) < 4)
                    fb.push_back(cfg_img.trailer_byte);
                else
                    fb.push_back(byte_t'($urandom_range(0, 255)));
            end
        end
        else
        begin
            if (aligned)
                align_to_start();
            repeat (RUN) fb.push_back(cfg_img.header_byte);
            fb.push_back(row.id);
            ck_sum = row.id;
            if (row.shape == SHAPE_LONG)
            begin
                for (int j = 0; j < 8; j++)
                begin
                    fb.push_back(row.payload[63 - 8*j -: 8]);
                    ck_sum = ck_sum + row.payload[63 - 8*j -: 8];
                end
            end
            fb.push_back(ck_sum);
            repeat (RUN) fb.push_back(cfg_img.trailer_byte);
            // corrupt one byte of the chosen part
            flip = byte_t'($urandom_range(1, 255));
            case (row.defect)
                DEF_HEADER:   fb[$urandom_range(0, RUN - 1)] ^= flip;
                DEF_CHECKSUM: fb[fb.size() - RUN - 1] ^= flip;
                DEF_TRAILER:  fb[$urandom_range(fb.size() - RUN, fb.size() - 1)] ^= flip;
                default: ;
            endcase
        end
        for (int i = 0; i < fb.size(); i++)
        begin
            send_byte(fb[i], row.typed && (i == fb.size() - 1), row.exp_hit, row.exp_cmd);
            frame_items++;
        end
    endtask

    // Mostly well-formed frames with random content, some broken, some noise
    function automatic frame_row_t random_row();
        frame_row_t row;
        int         pick;
        row.typed   = 1'b0;
        row.exp_hit = 1'b0;
        row.exp_cmd = NO_CMD;
        pick = $urandom_range(0, 99);
        row.shape = (pick < 10) ? SHAPE_NOISE : (pick < 65) ? SHAPE_LONG : SHAPE_SHORT;
        pick = $urandom_range(0, 99);
        row.defect = (pick < 85) ? DEF_NONE : (pick < 90) ? DEF_HEADER :
                     (pick < 95) ? DEF_CHECKSUM : DEF_TRAILER;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            row.id = cfg_img.set_pwm_id;
        else if (pick < 7)
            row.id = cfg_img.telemetry_id;
        else if (pick < 9)
            row.id = cfg_img.read_angle_id;
        else
            row.id = byte_t'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            row.payload = '0;
        else if (pick == 1)
            row.payload = '1;
        else
            row.payload = {$urandom, $urandom};
        return row;
    endfunction

    // Register write: one cycle with the write enable high
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input byte_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_HEADER_BYTE:   cfg_img.header_byte   = value;
            CFG_TRAILER_BYTE:  cfg_img.trailer_byte  = value;
            CFG_TELEMETRY_ID:  cfg_img.telemetry_id  = value;
            CFG_SET_PWM_ID:    cfg_img.set_pwm_id    = value;
            CFG_READ_ANGLE_ID: cfg_img.read_angle_id = value;
            default: ;
        endcase
    endtask

    // All five registers, then junk to the unused indexes
    task automatic apply_settings(input cfg_t s);
        write_reg(CFG_HEADER_BYTE, s.header_byte);
        write_reg(CFG_TRAILER_BYTE, s.trailer_byte);
        write_reg(CFG_TELEMETRY_ID, s.telemetry_id);
        write_reg(CFG_SET_PWM_ID, s.set_pwm_id);
        write_reg(CFG_READ_ANGLE_ID, s.read_angle_id);
        for (int i = int'(CFG_READ_ANGLE_ID) + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), byte_t'($urandom_range(0, 255)));
        cfg_we <= 1'b0;
    endtask

    // Stop offering, let every result drain, then let the pipeline settle
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at result %0d: %s got %h, expected %h",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    // Stimulus
    initial
    begin : stimulus
        cfg_t setting;
        int unsigned goal;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_frame(directed_rows[r], 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                settle_idle();
                setting = phase_cfg[ph];
                if (ph == NUM_PHASES - 1)
                    setting = $bits(cfg_t)'({$urandom, $urandom});
                apply_settings(setting);
            end
            if (ph == PRESSURE_PHASE)
                hold_req = 1'b1;
            goal = frame_items + ITEMS_PER_PHASE;
            while (frame_items < goal)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                send_frame(random_row(), $urandom_range(0, 9) != 0);
            end
        end

        settle_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, one long hold on request
    initial
    begin : receiver
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = idle_on ? $urandom_range(0, 3) : 0;
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each taken result with the oldest queued command
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
                report_mismatch("unexpected result, kind", 16'(command_kind), 16'h0);
            else
            begin
                want_cmd = pending_cmds.pop_front();
                if (command_kind !== want_cmd.kind)
                    report_mismatch("command_kind", 16'(command_kind), 16'(want_cmd.kind));
                if (pwm_a !== want_cmd.pwm_a)
                    report_mismatch("pwm_a", pwm_a, want_cmd.pwm_a);
                if (pwm_b !== want_cmd.pwm_b)
                    report_mismatch("pwm_b", pwm_b, want_cmd.pwm_b);
                if (pwm_c !== want_cmd.pwm_c)
                    report_mismatch("pwm_c", pwm_c, want_cmd.pwm_c);
                if (pwm_d !== want_cmd.pwm_d)
                    report_mismatch("pwm_d", pwm_d, want_cmd.pwm_d);
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

endmodule
